@@ hdl/ook_pwm_color_frame_sequencer_top_macros.svh @@
// Assertion helpers for the frame sequencer.
`ifndef OOK_PWM_COLOR_FRAME_SEQUENCER_TOP_MACROS_SVH
`define OOK_PWM_COLOR_FRAME_SEQUENCER_TOP_MACROS_SVH

// Check a property outside reset.
`define OPFS_CHECK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property at every edge, reset included.
`define OPFS_CHECK_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hdl/opfs_pkg.sv @@
package opfs_pkg;

  localparam int PAYLOAD_COPIES = 2;
  localparam int PRE_ENTRIES    = 8;
  localparam int PAY_ENTRIES    = 114;
  localparam int BIT_ENTRIES    = 112;
  localparam int POS_W          = 8;
  localparam int DUR_W          = 16;

  localparam logic [POS_W-1:0] FRAME_ENTRIES =
    POS_W'(PRE_ENTRIES + PAYLOAD_COPIES * PAY_ENTRIES);

  typedef enum logic {
    OP_LATCH = 1'b0,
    OP_PULL  = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    REG_CHECK_NIBBLE = 3'd0,
    REG_SHORT_PULSE  = 3'd1,
    REG_LONG_PULSE   = 3'd2,
    REG_FRAME_GAP    = 3'd3,
    REG_BLOCK_GAP    = 3'd4
  } reg_index_t;

  typedef struct packed {
    logic             level;
    logic [DUR_W-1:0] duration_us;
    logic             exhausted;
    logic             last_entry;
  } result_t;

endpackage

@@ hdl/ook_pwm_color_frame_sequencer_top.sv @@
// Channel   Direction  Handshake             Payload
// in        sink       in_valid / in_stall   op, red, green, blue
// out       source     out_valid / out_stall level, duration_us, exhausted, last_entry
// cfg       sink       cfg_valid / cfg_ready cfg_index, cfg_data
//
// One item per cycle when not stalled: a pull decodes the position counter and colour
// store into one entry, registered in the output buffer. A latch gives no result.
// Reset (rst, synchronous) clears the frame state and loads the default pulse timing.
// A two-deep output buffer (result register plus skid register) parts the channels;
// in_stall rises only when the skid register is full, so the input side never waits
// on the output stall combinationally. cfg_ready is always high.
`include "ook_pwm_color_frame_sequencer_top_macros.svh"

module ook_pwm_color_frame_sequencer_top
  import opfs_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  // input channel
  input  logic             in_valid,
  output logic             in_stall,
  input  logic             op,
  input  logic [3:0]       red,
  input  logic [3:0]       green,
  input  logic [3:0]       blue,
  // result channel
  output logic             out_valid,
  input  logic             out_stall,
  output logic             level,
  output logic [DUR_W-1:0] duration_us,
  output logic             exhausted,
  output logic             last_entry,
  // configuration write channel
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [2:0]       cfg_index,
  input  logic [DUR_W-1:0] cfg_data
);

  // configuration registers
  logic [3:0]       check_nibble;
  logic [DUR_W-1:0] short_pulse;
  logic [DUR_W-1:0] long_pulse;
  logic [DUR_W-1:0] frame_gap;
  logic [DUR_W-1:0] block_gap;

  // frame state
  logic [11:0]      colour;
  logic [POS_W-1:0] position;
  logic             loaded;

  // output buffer
  result_t          main_res;
  result_t          skid_res;
  logic             skid_valid;

  logic             in_xfer;
  logic             pull;
  logic             out_xfer;
  result_t          entry;
  logic             entry_live;

  assign cfg_ready = 1'b1;
  assign in_stall  = skid_valid;
  assign in_xfer   = in_valid && !in_stall;
  assign pull      = in_xfer && (op == OP_PULL);
  assign out_xfer  = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      check_nibble <= 4'd0;
      short_pulse  <= DUR_W'(200);
      long_pulse   <= DUR_W'(600);
      frame_gap    <= DUR_W'(1600);
      block_gap    <= DUR_W'(5600);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_CHECK_NIBBLE: check_nibble <= cfg_data[3:0];
        REG_SHORT_PULSE:  short_pulse  <= cfg_data;
        REG_LONG_PULSE:   long_pulse   <= cfg_data;
        REG_FRAME_GAP:    frame_gap    <= cfg_data;
        REG_BLOCK_GAP:    block_gap    <= cfg_data;
        default: ;  // drop writes to unmapped indexes
      endcase
    end
  end

  // Entry decode. The frame is an 8-entry preamble (bits 0,1,0, stop mark, gap)
  // followed by payload copies of 114 entries: 56 bits as high/low halves,
  // then a short mark and a gap.
  logic [POS_W-1:0] pay_pos;
  logic             second_copy;
  logic [6:0]       q;
  logic [7:0]       pay_byte;
  logic [3:0]       red_n, green_n, blue_n;
  logic             bit_one;
  logic             half_high;
  logic             final_copy;

  assign red_n   = colour[11:8];
  assign green_n = colour[7:4];
  assign blue_n  = colour[3:0];

  always_comb begin
    pay_pos     = position - POS_W'(PRE_ENTRIES);
    second_copy = (pay_pos >= POS_W'(PAY_ENTRIES));
    q           = second_copy ? 7'(pay_pos - POS_W'(PAY_ENTRIES)) : pay_pos[6:0];
    final_copy  = ((int'(second_copy) + 1) >= PAYLOAD_COPIES);

    case (q[6:4])
      3'd0:    pay_byte = 8'hAA;
      3'd1:    pay_byte = 8'hFF;
      3'd2:    pay_byte = {red_n, 4'd0};
      3'd3:    pay_byte = {green_n, 4'd0};
      3'd4:    pay_byte = {blue_n, 4'd0};
      3'd5:    pay_byte = {red_n ^ green_n ^ blue_n ^ check_nibble, check_nibble};
      default: pay_byte = 8'h00;
    endcase

    entry_live = loaded && (position < FRAME_ENTRIES);
    entry      = '0;
    bit_one    = 1'b0;
    half_high  = 1'b0;

    if (!entry_live) begin
      entry.exhausted = 1'b1;
    end else if (position < POS_W'(PRE_ENTRIES)) begin
      // preamble: bit pairs at 0..5, where only the middle bit is a one
      bit_one   = (position[2:1] == 2'd1);
      half_high = !position[0];
      if (position < POS_W'(6)) begin
        entry.level       = half_high;
        entry.duration_us = (bit_one == half_high) ? short_pulse : long_pulse;
      end else if (position == POS_W'(6)) begin
        entry.level       = 1'b1;
        entry.duration_us = short_pulse;
      end else begin
        entry.duration_us = frame_gap;
      end
    end else begin
      bit_one   = pay_byte[3'd7 - q[3:1]];
      half_high = !q[0];
      if (q < 7'(BIT_ENTRIES)) begin
        entry.level       = half_high;
        entry.duration_us = (bit_one == half_high) ? short_pulse : long_pulse;
      end else if (q == 7'(BIT_ENTRIES)) begin
        entry.level       = 1'b1;
        entry.duration_us = short_pulse;
      end else if (final_copy) begin
        entry.duration_us = block_gap;
        entry.last_entry  = 1'b1;
      end else begin
        entry.duration_us = frame_gap;
      end
    end
  end

  // Frame state: a latch rewinds, a pull advances only while entries remain.
  always_ff @(posedge clk) begin
    if (rst) begin
      colour   <= 12'd0;
      position <= '0;
      loaded   <= 1'b0;
    end else if (in_xfer) begin
      if (op == OP_LATCH) begin
        colour   <= {red, green, blue};
        position <= '0;
        loaded   <= 1'b1;
      end else if (entry_live) begin
        position <= position + POS_W'(1);
      end
    end
  end

  // Output buffer: refill from skid on a transfer, park a new result in skid
  // when the result register is held by a stall.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_xfer || !out_valid) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid  <= pull;
      end
    end else if (pull) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_xfer || !out_valid) begin
      main_res <= skid_valid ? skid_res : entry;
    end else if (pull) begin
      skid_res <= entry;
    end
  end

  assign level       = main_res.level;
  assign duration_us = main_res.duration_us;
  assign exhausted   = main_res.exhausted;
  assign last_entry  = main_res.last_entry;

  `OPFS_CHECK_ALWAYS(a_reset_empties, rst |=> !out_valid && !skid_valid,
                     "buffer not empty after reset")
  `OPFS_CHECK(a_skid_behind_main, skid_valid |-> out_valid,
              "skid holds data while result register is empty")
  `OPFS_CHECK(a_skid_fill_on_stall, $rose(skid_valid) |-> $past(out_valid && out_stall),
              "skid filled without a stall")
  `OPFS_CHECK(a_position_bound, position <= FRAME_ENTRIES,
              "position ran past the frame")
  `OPFS_CHECK(a_exhausted_entry,
              out_valid && exhausted |-> !level && duration_us == '0 && !last_entry,
              "exhausted entry not the reset entry")

endmodule
